### rtl/core/decc_pkg.sv
// ----------------------------------------------------------------------------
// decc_pkg
// Shared types, codes and helpers for the two-operand decimal calculator.
// ----------------------------------------------------------------------------
package decc_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_BADOP = 2'd1;
    localparam t_status ST_DIVZ  = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // expression handed from the parser to the execute side
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        t_op         op;
        logic        bad_op;
    } t_job;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // acc * 10 + d, wrapping at 32 bits
    function automatic logic [31:0] acc_digit(input logic [31:0] acc, input logic [3:0] d);
        acc_digit = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, d};
    endfunction

    function automatic t_op op_decode(input logic [7:0] c);
        case (c)
            CH_PLUS:  op_decode = OP_ADD;
            CH_MINUS: op_decode = OP_SUB;
            CH_STAR:  op_decode = OP_MUL;
            default:  op_decode = OP_DIV;
        endcase
    endfunction

endpackage

### rtl/core/decc_front.sv
// ----------------------------------------------------------------------------
// decc_front
// Character parser: accumulates both operands, holds the operator and
// pushes one finished expression (or a bad-operator record) into the queue.
// ----------------------------------------------------------------------------
module decc_front import decc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    output logic       o_stall,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic PH_FIRST  = 1'b0;
    localparam logic PH_SECOND = 1'b1;

    logic        r_phase;
    logic [31:0] r_first;
    logic [31:0] r_second;
    t_op         r_op;

    logic        accept;
    logic        is_digit;
    logic        is_op;
    logic [3:0]  digit;
    logic [7:0]  digit_wide;

    assign o_stall    = i_full;
    assign accept     = i_valid && !i_full;
    assign is_digit   = (i_char_code >= CH_0) && (i_char_code <= CH_9);
    assign is_op      = (i_char_code == CH_PLUS) || (i_char_code == CH_MINUS) ||
                        (i_char_code == CH_STAR) || (i_char_code == CH_SLASH);
    assign digit_wide = i_char_code - CH_0;
    assign digit      = digit_wide[3:0];

    // non-digits end the expression in phase two, non-operators in phase one
    assign o_push = accept && !is_digit && ((r_phase == PH_SECOND) || !is_op);

    always_comb begin
        if (r_phase == PH_FIRST) begin
            o_job.left   = r_first;
            o_job.right  = 32'd0;
            o_job.op     = OP_ADD;
            o_job.bad_op = 1'b1;
        end else begin
            o_job.left   = r_first;
            o_job.right  = r_second;
            o_job.op     = r_op;
            o_job.bad_op = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_first  <= 32'd0;
            r_second <= 32'd0;
            r_op     <= OP_ADD;
        end else if (accept) begin
            if (is_digit) begin
                if (r_phase == PH_FIRST) begin
                    r_first <= acc_digit(r_first, digit);
                end else begin
                    r_second <= acc_digit(r_second, digit);
                end
            end else if ((r_phase == PH_FIRST) && is_op) begin
                r_op    <= op_decode(i_char_code);
                r_phase <= PH_SECOND;
            end else begin
                r_phase  <= PH_FIRST;
                r_first  <= 32'd0;
                r_second <= 32'd0;
                r_op     <= OP_ADD;
            end
        end
    end

endmodule

### rtl/core/decc_fifo.sv
// ----------------------------------------------------------------------------
// decc_fifo
// Short queue of parsed expressions between parser and execute unit.
// ----------------------------------------------------------------------------
module decc_fifo import decc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

endmodule

### rtl/core/decc_back.sv
// ----------------------------------------------------------------------------
// decc_back
// Execute unit: add/sub in one step, registered multiply, 32-step restoring
// divide with sign fix-up, then an output register toward the consumer.
// ----------------------------------------------------------------------------
module decc_back import decc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_job         i_job,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_value,
    output t_status      o_status,
    output logic [31:0]  o_left_operand,
    output logic [31:0]  o_right_operand,
    output t_op          o_op_code
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    t_job        r_job;
    logic [31:0] r_res;
    t_status     r_status;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_divisor;
    logic        r_neg;
    logic [4:0]  r_cnt;

    logic        r_out_valid;
    logic [31:0] r_out_value;
    t_status     r_out_status;
    logic [31:0] r_out_left;
    logic [31:0] r_out_right;
    t_op         r_out_op;

    logic [31:0] prod;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        out_free;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_out_valid || !i_stall;

    // only the low word of the product is kept
    assign prod  = r_job.left * r_job.right;
    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_divisor};
    assign ge    = !diff[32];
    assign mag_a = i_job.left[31]  ? (~i_job.left + 32'd1)  : i_job.left;
    assign mag_b = i_job.right[31] ? (~i_job.right + 32'd1) : i_job.right;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_job.bad_op) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_job.op)
                            OP_MUL:  n_state = S_MUL;
                            OP_DIV:  n_state = (i_job.right == 32'd0) ? S_DONE : S_DIV;
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_MUL:  n_state = S_DONE;
            S_DIV:  n_state = (r_cnt == 5'd31) ? S_FIX : S_DIV;
            S_FIX:  n_state = S_DONE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job     <= i_job;
                r_rem     <= 32'd0;
                r_quo     <= mag_a;
                r_divisor <= mag_b;
                r_neg     <= i_job.left[31] ^ i_job.right[31];
                r_cnt     <= 5'd0;
                if (i_job.bad_op) begin
                    r_status <= ST_BADOP;
                    r_res    <= 32'd0;
                end else begin
                    case (i_job.op)
                        OP_ADD: begin
                            r_status <= ST_OK;
                            r_res    <= i_job.left + i_job.right;
                        end
                        OP_SUB: begin
                            r_status <= ST_OK;
                            r_res    <= i_job.left - i_job.right;
                        end
                        OP_DIV: begin
                            r_status <= (i_job.right == 32'd0) ? ST_DIVZ : ST_OK;
                            r_res    <= 32'd0;
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_res    <= 32'd0;
                        end
                    endcase
                end
            end
            S_MUL: r_res <= prod;
            S_DIV: begin
                r_rem <= ge ? diff[31:0] : trial[31:0];
                r_quo <= {r_quo[30:0], ge};
                r_cnt <= r_cnt + 5'd1;
            end
            S_FIX: r_res <= r_neg ? (~r_quo + 32'd1) : r_quo;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_value  <= r_res;
            r_out_status <= r_status;
            r_out_left   <= r_job.left;
            r_out_right  <= r_job.right;
            r_out_op     <= r_job.op;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_value         = r_out_value;
    assign o_status        = r_out_status;
    assign o_left_operand  = r_out_left;
    assign o_right_operand = r_out_right;
    assign o_op_code       = r_out_op;

    a_div_only_for_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_job.op == OP_DIV) && !r_job.bad_op)
        else $error("divide loop running for a non-divide item");

    a_badop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_BADOP)) |->
            (r_out_value == 32'd0) && (r_out_right == 32'd0) && (r_out_op == OP_ADD))
        else $error("bad-operator result carries stray fields");

    a_divz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_DIVZ)) |->
            (r_out_value == 32'd0) && (r_out_right == 32'd0) && (r_out_op == OP_DIV))
        else $error("divide-by-zero result inconsistent");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while execute unit busy");

endmodule

### rtl/core/decimal_expression_calculator_unit.sv
// ----------------------------------------------------------------------------
// decimal_expression_calculator_unit
// Two-operand decimal calculator over an ASCII character stream.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   input    | i_valid / o_stall   | i_char_code
//   result   | o_valid / i_stall   | o_value o_status o_left_operand
//            |                     | o_right_operand o_op_code
//
// The parser accepts digits and the operator whenever o_stall is low.
// A terminator queues the expression; the execute unit pops it when idle and
// passes add, subtract and error results straight to its output register,
// multiply through a product state, divide through a 32-step loop and fix-up.
// The two-entry queue lets the parser keep reading while a divide runs;
// o_stall rises only when that queue is full.
// Reset (synchronous, active low) clears both operands, phase and queue.
// ----------------------------------------------------------------------------
module decimal_expression_calculator_unit import decc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic [1:0]  o_status,
    output logic [31:0] o_left_operand,
    output logic [31:0] o_right_operand,
    output logic [1:0]  o_op_code
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job queue_job;

    decc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .o_stall     (o_stall),
        .i_full      (full),
        .o_push      (push),
        .o_job       (front_job)
    );

    decc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    decc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_job           (queue_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value         (o_value),
        .o_status        (o_status),
        .o_left_operand  (o_left_operand),
        .o_right_operand (o_right_operand),
        .o_op_code       (o_op_code)
    );

endmodule
